>>> hw/rtl/ictt_pkg.sv
// ----------------------------------------------------------------------------
// ictt_pkg
// Shared types and constants of the idle connection timeout tracker.
// ----------------------------------------------------------------------------
package ictt_pkg;

   localparam int DEF_MAX_CONNS = 64;
   localparam int MAX_RESULTS   = 64;
   localparam int EXP_AW        = $clog2(MAX_RESULTS);
   localparam int NEXP_W        = EXP_AW + 1;
   localparam int ID_BITS       = 6;
   localparam int US_PER_MS     = 1000;
   localparam int TMO_US_W      = 26;   // 65535 * 1000 fits
   localparam int NUM_W         = 42;   // wait numerator in us below the saturation limit
   localparam int QUO_W         = 32;

   // divide by 1000 as a shift by 3 and a reciprocal multiply by 1/125,
   // exact for every numerator below 2**42
   localparam int          HALF_W    = 20;
   localparam int          ACC_W     = 4 * HALF_W;
   localparam int          RECIP_SH  = 46;
   localparam logic [39:0] RECIP_125 = 40'd562949953422;   // ceil(2**46 / 125)
   localparam int          DIV_STEPS = 4;

   localparam logic [15:0] TIMEOUT_RST    = 16'(5 * 1000);
   localparam logic [15:0] EMPTY_WAIT_RST = 16'(10000);
   localparam logic [64:0] SAT_LIM        = 65'd4294967296000;

   typedef enum logic [1:0] {
      FUNC_OPEN     = 2'd0,
      FUNC_ACTIVITY = 2'd1,
      FUNC_CLOSE    = 2'd2,
      FUNC_TICK     = 2'd3
   } func_type;

   typedef enum logic {
      CSR_TIMEOUT    = 1'b0,
      CSR_EMPTY_WAIT = 1'b1
   } csr_idx_type;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_DECIDE, S_LINK, S_TICK,
      S_WRD, S_WSUB, S_WNUM, S_DIV, S_EMIT
   } state_type;

   typedef enum logic [3:0] {
      DP_NOP, DP_CLEAR, DP_ACCEPT, DP_DECIDE, DP_LINK, DP_TICK,
      DP_WSUB, DP_WNUM, DP_DIV, DP_EMIT
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } cmd_type;

   typedef struct packed {
      logic clear_done;
      logic req_tick;
      logic need_link;
      logic tick_more;
      logic empty;
      logic div_last;
      logic emit_last;
   } status_type;

endpackage

>>> hw/rtl/ictt_ram.sv
// ----------------------------------------------------------------------------
// ictt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ictt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> hw/rtl/ictt_ctrl.sv
// ----------------------------------------------------------------------------
// ictt_ctrl
// Sequencer: steps the datapath through clear, list update, tick scan,
// wait computation and result transfers.
// ----------------------------------------------------------------------------
module ictt_ctrl
   import ictt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  status_type status,
   output logic       busy,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR:  if (status.clear_done) state_in = S_IDLE;
         S_IDLE:   if (start) state_in = status.req_tick ? S_TICK : S_DECIDE;
         S_DECIDE: state_in = status.need_link ? S_LINK : S_WRD;
         S_LINK:   state_in = S_WRD;
         S_TICK:   if (!status.tick_more) state_in = S_WRD;
         S_WRD:    state_in = status.empty ? S_EMIT : S_WSUB;
         S_WSUB:   state_in = S_WNUM;
         S_WNUM:   state_in = S_DIV;
         S_DIV:    if (status.div_last) state_in = S_EMIT;
         S_EMIT:   if (status.emit_last) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   always_comb begin
      busy   = (state_ff != S_IDLE);
      cmd.op = DP_NOP;
      unique case (state_ff)
         S_CLEAR:  cmd.op = DP_CLEAR;
         S_IDLE:   cmd.op = start ? DP_ACCEPT : DP_NOP;
         S_DECIDE: cmd.op = DP_DECIDE;
         S_LINK:   cmd.op = DP_LINK;
         S_TICK:   cmd.op = DP_TICK;
         S_WRD:    cmd.op = DP_NOP;
         S_WSUB:   cmd.op = DP_WSUB;
         S_WNUM:   cmd.op = DP_WNUM;
         S_DIV:    cmd.op = DP_DIV;
         S_EMIT:   cmd.op = DP_EMIT;
         default:  cmd.op = DP_NOP;
      endcase
   end

endmodule

>>> hw/rtl/ictt_dp.sv
// ----------------------------------------------------------------------------
// ictt_dp
// Datapath: list memories, head/tail/count, expiry compare, wait
// arithmetic with a four-step reciprocal divide by 1000, and result registers.
// ----------------------------------------------------------------------------
module ictt_dp
   import ictt_pkg::*;
#(
   parameter int MAX_CONNS = DEF_MAX_CONNS
) (
   input  logic          clock,
   input  logic          reset,
   input  cmd_type       cmd,
   output status_type    status,
   input  logic [1:0]    req_func,
   input  logic [5:0]    req_conn_id,
   input  logic [63:0]   req_now_us,
   input  logic          csr_we,
   input  logic          csr_index,
   input  logic [15:0]   csr_wdata,
   output logic          rsp_strobe,
   output logic          rsp_expired_valid,
   output logic [5:0]    rsp_expired_conn,
   output logic          rsp_rejected,
   output logic          rsp_list_empty,
   output logic [31:0]   rsp_next_wait_ms,
   output logic          rsp_last
);

   localparam int ID_W  = $clog2(MAX_CONNS);
   localparam int CNT_W = $clog2(MAX_CONNS + 1);
   localparam int DIV_CW = $clog2(DIV_STEPS);

   // configuration
   logic [15:0]         tmo_ff, tmo_in;
   logic [15:0]         ewait_ff, ewait_in;
   logic [TMO_US_W-1:0] tmo_us_ff, tmo_us_in;

   // request
   logic [1:0]          func_ff, func_in;
   logic [5:0]          id_ff, id_in;
   logic [63:0]         now_ff, now_in;
   logic [64:0]         nowp_ff, nowp_in;
   logic                in_range_ff, in_range_in;

   // list state
   logic [ID_W-1:0]     head_ff, head_in;
   logic [ID_W-1:0]     tail_ff, tail_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [ID_W-1:0]     clr_ff, clr_in;
   logic [NEXP_W-1:0]   nexp_ff, nexp_in;
   logic [NEXP_W-1:0]   emit_idx_ff, emit_idx_in;
   logic                rej_ff, rej_in;

   // wait arithmetic
   logic                ge_ff, ge_in;
   logic [63:0]         diff_ff, diff_in;
   logic                sat_ff, sat_in;
   logic [2*HALF_W-1:0] m_ff, m_in;
   logic [ACC_W-1:0]    acc_ff, acc_in;
   logic [DIV_CW-1:0]   dcnt_ff, dcnt_in;

   // result registers
   logic                strobe_ff, strobe_in;
   logic                xv_ff, xv_in;
   logic [5:0]          xc_ff, xc_in;
   logic                rj_ff, rj_in;
   logic                le_ff, le_in;
   logic [31:0]         nw_ff, nw_in;
   logic                last_ff, last_in;

   // memory ports
   logic                act_we, act_wd, act_rd;
   logic [ID_W-1:0]     act_wa, act_ra;
   logic                time_we;
   logic [ID_W-1:0]     time_wa, time_ra;
   logic [63:0]         time_wd, time_rd;
   logic                next_we, prev_we;
   logic [ID_W-1:0]     next_wa, next_wd, next_ra, next_rd;
   logic [ID_W-1:0]     prev_wa, prev_wd, prev_ra, prev_rd;
   logic                exp_we;
   logic [EXP_AW-1:0]   exp_wa, exp_ra;
   logic [ID_W-1:0]     exp_wd, exp_rd;

   // helpers
   logic [ID_W-1:0]     sid;
   logic                op_ok;
   logic                due;
   logic                remove;
   logic [64:0]         sum65;
   logic [NUM_W-1:0]    numv;
   logic [HALF_W-1:0]   mul_a, mul_b;
   logic [2*HALF_W-1:0] pp;
   logic [ACC_W-1:0]    pp_sh;
   logic                multi;
   logic [31:0]         wait_val;

   ictt_ram #(.WIDTH(1), .DEPTH(MAX_CONNS)) u_act (
      .clock, .we(act_we), .waddr(act_wa), .wdata(act_wd), .raddr(act_ra), .rdata(act_rd)
   );
   ictt_ram #(.WIDTH(64), .DEPTH(MAX_CONNS)) u_time (
      .clock, .we(time_we), .waddr(time_wa), .wdata(time_wd), .raddr(time_ra),
      .rdata(time_rd)
   );
   ictt_ram #(.WIDTH(ID_W), .DEPTH(MAX_CONNS)) u_next (
      .clock, .we(next_we), .waddr(next_wa), .wdata(next_wd), .raddr(next_ra),
      .rdata(next_rd)
   );
   ictt_ram #(.WIDTH(ID_W), .DEPTH(MAX_CONNS)) u_prev (
      .clock, .we(prev_we), .waddr(prev_wa), .wdata(prev_wd), .raddr(prev_ra),
      .rdata(prev_rd)
   );
   ictt_ram #(.WIDTH(ID_W), .DEPTH(MAX_RESULTS)) u_exp (
      .clock, .we(exp_we), .waddr(exp_wa), .wdata(exp_wd), .raddr(exp_ra), .rdata(exp_rd)
   );

   assign sid    = ID_W'(id_ff);
   assign op_ok  = in_range_ff && ((func_ff == FUNC_OPEN) ? !act_rd : act_rd);
   assign due    = (({1'b0, time_rd} + 65'(tmo_us_ff)) < nowp_ff);
   assign remove = (cnt_ff != '0) && (nexp_ff != NEXP_W'(MAX_RESULTS)) && due;
   assign multi  = (func_ff == FUNC_TICK) && (nexp_ff != '0);

   // one 20 x 20 partial product of numerator and reciprocal per step
   assign mul_a = dcnt_ff[1] ? m_ff[2*HALF_W-1:HALF_W] : m_ff[HALF_W-1:0];
   assign mul_b = dcnt_ff[0] ? RECIP_125[2*HALF_W-1:HALF_W] : RECIP_125[HALF_W-1:0];
   assign pp    = mul_a * mul_b;

   always_comb begin
      if (dcnt_ff == DIV_CW'(0)) begin
         pp_sh = ACC_W'(pp);
      end else if (dcnt_ff == DIV_CW'(DIV_STEPS - 1)) begin
         pp_sh = ACC_W'(pp) << (2 * HALF_W);
      end else begin
         pp_sh = ACC_W'(pp) << HALF_W;
      end
   end

   always_comb begin
      if (cnt_ff == '0) begin
         wait_val = 32'(ewait_ff);
      end else if (sat_ff) begin
         wait_val = '1;
      end else begin
         wait_val = acc_ff[RECIP_SH +: QUO_W];
      end
   end

   always_comb begin
      status.clear_done = (clr_ff == ID_W'(MAX_CONNS - 1));
      status.req_tick   = (req_func == FUNC_TICK);
      status.need_link  = op_ok && (func_ff == FUNC_ACTIVITY);
      status.tick_more  = remove;
      status.empty      = (cnt_ff == '0);
      status.div_last   = (dcnt_ff == DIV_CW'(DIV_STEPS - 1));
      status.emit_last  = !multi || (emit_idx_ff == nexp_ff - NEXP_W'(1));
   end

   always_comb begin
      tmo_in = tmo_ff;  ewait_in = ewait_ff;  tmo_us_in = tmo_us_ff;
      func_in = func_ff;  id_in = id_ff;  now_in = now_ff;  nowp_in = nowp_ff;
      in_range_in = in_range_ff;
      head_in = head_ff;  tail_in = tail_ff;  cnt_in = cnt_ff;  clr_in = clr_ff;
      nexp_in = nexp_ff;  emit_idx_in = emit_idx_ff;  rej_in = rej_ff;
      ge_in = ge_ff;  diff_in = diff_ff;  sat_in = sat_ff;
      m_in = m_ff;  acc_in = acc_ff;  dcnt_in = dcnt_ff;
      strobe_in = 1'b0;  xv_in = xv_ff;  xc_in = xc_ff;  rj_in = rj_ff;
      le_in = le_ff;  nw_in = nw_ff;  last_in = last_ff;
      sum65 = '0;  numv = '0;

      act_we = 1'b0;  act_wa = sid;  act_wd = 1'b0;
      act_ra = ID_W'(req_conn_id);
      time_we = 1'b0;  time_wa = sid;  time_wd = now_ff;  time_ra = head_ff;
      next_we = 1'b0;  next_wa = tail_ff;  next_wd = sid;
      next_ra = (req_func == FUNC_TICK) ? head_ff : ID_W'(req_conn_id);
      prev_we = 1'b0;  prev_wa = sid;  prev_wd = tail_ff;
      prev_ra = ID_W'(req_conn_id);
      exp_we = 1'b0;  exp_wa = nexp_ff[EXP_AW-1:0];  exp_wd = head_ff;

      if (csr_we) begin
         unique case (csr_idx_type'(csr_index))
            CSR_TIMEOUT: begin
               tmo_in    = csr_wdata;
               tmo_us_in = TMO_US_W'(csr_wdata) * TMO_US_W'(US_PER_MS);
            end
            CSR_EMPTY_WAIT: ewait_in = csr_wdata;
            default: ;
         endcase
      end

      unique case (cmd.op)
         DP_CLEAR: begin
            act_we = 1'b1;
            act_wa = clr_ff;
            act_wd = 1'b0;
            clr_in = clr_ff + ID_W'(1);
         end
         DP_ACCEPT: begin
            func_in     = req_func;
            id_in       = req_conn_id;
            now_in      = req_now_us;
            nowp_in     = {1'b0, req_now_us} + 65'(US_PER_MS);
            in_range_in = (32'(req_conn_id) < 32'(MAX_CONNS));
            nexp_in     = '0;
            emit_idx_in = '0;
            rej_in      = 1'b0;
         end
         DP_DECIDE: begin
            rej_in = !op_ok;
            if (op_ok) begin
               if (func_ff == FUNC_OPEN) begin
                  // set active, stamp and append at the tail
                  act_we  = 1'b1;
                  act_wd  = 1'b1;
                  time_we = 1'b1;
                  if (cnt_ff == '0) begin
                     head_in = sid;
                  end else begin
                     next_we = 1'b1;
                     prev_we = 1'b1;
                  end
                  tail_in = sid;
                  cnt_in  = cnt_ff + CNT_W'(1);
               end else begin
                  // unlink the slot
                  if (sid != head_ff) begin
                     next_we = 1'b1;
                     next_wa = prev_rd;
                     next_wd = next_rd;
                  end
                  if (sid != tail_ff) begin
                     prev_we = 1'b1;
                     prev_wa = next_rd;
                     prev_wd = prev_rd;
                  end
                  head_in = (sid == head_ff) ? next_rd : head_ff;
                  tail_in = (sid == tail_ff) ? prev_rd : tail_ff;
                  cnt_in  = cnt_ff - CNT_W'(1);
                  if (cnt_ff == CNT_W'(1)) begin
                     head_in = '0;
                     tail_in = '0;
                  end
                  if (func_ff == FUNC_CLOSE) begin
                     act_we = 1'b1;
                     act_wd = 1'b0;
                  end
               end
            end
         end
         DP_LINK: begin
            time_we = 1'b1;
            if (cnt_ff == '0) begin
               head_in = sid;
            end else begin
               next_we = 1'b1;
               prev_we = 1'b1;
            end
            tail_in = sid;
            cnt_in  = cnt_ff + CNT_W'(1);
         end
         DP_TICK: begin
            if (remove) begin
               // pop the head and queue it for transfer
               act_we  = 1'b1;
               act_wa  = head_ff;
               act_wd  = 1'b0;
               exp_we  = 1'b1;
               nexp_in = nexp_ff + NEXP_W'(1);
               cnt_in  = cnt_ff - CNT_W'(1);
               head_in = (cnt_ff == CNT_W'(1)) ? '0 : next_rd;
               if (cnt_ff == CNT_W'(1)) begin
                  tail_in = '0;
               end
               time_ra = next_rd;
               next_ra = next_rd;
            end else begin
               next_ra = head_ff;
            end
         end
         DP_WSUB: begin
            ge_in   = (time_rd >= now_ff);
            diff_in = (time_rd >= now_ff) ? (time_rd - now_ff) : (now_ff - time_rd);
         end
         DP_WNUM: begin
            if (ge_ff) begin
               sum65  = {1'b0, diff_ff} + 65'(tmo_us_ff);
               sat_in = (sum65 >= SAT_LIM);
               numv   = sum65[NUM_W-1:0];
            end else begin
               sat_in = 1'b0;
               if (diff_ff >= 64'(tmo_us_ff)) begin
                  numv = '0;
               end else begin
                  numv = NUM_W'(tmo_us_ff - diff_ff[TMO_US_W-1:0]);
               end
            end
            // drop the factor 8 now, divide by 125 in the following steps
            m_in    = (2 * HALF_W)'(numv[NUM_W-1:3]);
            acc_in  = '0;
            dcnt_in = '0;
         end
         DP_DIV: begin
            // accumulate one partial product per cycle
            acc_in  = acc_ff + pp_sh;
            dcnt_in = dcnt_ff + DIV_CW'(1);
         end
         DP_EMIT: begin
            strobe_in   = 1'b1;
            xv_in       = multi;
            xc_in       = multi ? 6'(exp_rd) : 6'd0;
            rj_in       = rej_ff;
            le_in       = (cnt_ff == '0);
            last_in     = status.emit_last;
            nw_in       = status.emit_last ? wait_val : 32'd0;
            emit_idx_in = emit_idx_ff + NEXP_W'(1);
         end
         default: ;
      endcase

      exp_ra = emit_idx_in[EXP_AW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tmo_ff    <= TIMEOUT_RST;
         ewait_ff  <= EMPTY_WAIT_RST;
         tmo_us_ff <= TMO_US_W'(TIMEOUT_RST) * TMO_US_W'(US_PER_MS);
         head_ff   <= '0;
         tail_ff   <= '0;
         cnt_ff    <= '0;
         clr_ff    <= '0;
         strobe_ff <= 1'b0;
      end else begin
         tmo_ff    <= tmo_in;
         ewait_ff  <= ewait_in;
         tmo_us_ff <= tmo_us_in;
         head_ff   <= head_in;
         tail_ff   <= tail_in;
         cnt_ff    <= cnt_in;
         clr_ff    <= clr_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff     <= func_in;
      id_ff       <= id_in;
      now_ff      <= now_in;
      nowp_ff     <= nowp_in;
      in_range_ff <= in_range_in;
      nexp_ff     <= nexp_in;
      emit_idx_ff <= emit_idx_in;
      rej_ff      <= rej_in;
      ge_ff       <= ge_in;
      diff_ff     <= diff_in;
      sat_ff      <= sat_in;
      m_ff        <= m_in;
      acc_ff      <= acc_in;
      dcnt_ff     <= dcnt_in;
      xv_ff       <= xv_in;
      xc_ff       <= xc_in;
      rj_ff       <= rj_in;
      le_ff       <= le_in;
      nw_ff       <= nw_in;
      last_ff     <= last_in;
   end

   assign rsp_strobe        = strobe_ff;
   assign rsp_expired_valid = xv_ff;
   assign rsp_expired_conn  = xc_ff;
   assign rsp_rejected      = rj_ff;
   assign rsp_list_empty    = le_ff;
   assign rsp_next_wait_ms  = nw_ff;
   assign rsp_last          = last_ff;

endmodule

>>> hw/rtl/idle_connection_timeout_tracker.sv
// ----------------------------------------------------------------------------
// idle_connection_timeout_tracker
// Least-recently-active list of connection slots with idle timeout expiry.
// ----------------------------------------------------------------------------
// Issue an operation by raising start while busy is low; it is taken at that
// clock edge. Results come back on the rsp_ ports, one per cycle of
// rsp_strobe, and cannot be stalled: capture every strobe. A tick returns
// one transfer per expired slot (up to 64) and otherwise a single transfer;
// open, activity and close always return one. rsp_last marks the final
// transfer of an operation, which alone carries next_wait_ms. Busy drops in
// the cycle of the final strobe, so the next start is taken at the edge that
// ends it. An operation that leaves the list empty skips the wait
// arithmetic. The tick scan removes one expired slot per cycle, the wait is
// divided by 1000 with a four-step reciprocal multiply, and results go out
// one per cycle. After reset busy stays high while the active-flag memory is
// cleared. Write the csr_ registers only while idle.
// ----------------------------------------------------------------------------
module idle_connection_timeout_tracker
   import ictt_pkg::*;
#(
   parameter int MAX_CONNS = DEF_MAX_CONNS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_func,
   input  logic [5:0]  req_conn_id,
   input  logic [63:0] req_now_us,
   output logic        rsp_strobe,
   output logic        rsp_expired_valid,
   output logic [5:0]  rsp_expired_conn,
   output logic        rsp_rejected,
   output logic        rsp_list_empty,
   output logic [31:0] rsp_next_wait_ms,
   output logic        rsp_last,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);

   cmd_type    cmd;
   status_type status;

   // sequence the operation
   ictt_ctrl u_ctrl (
      .clock, .reset, .start, .status, .busy, .cmd
   );

   // hold the list and do the arithmetic
   ictt_dp #(.MAX_CONNS(MAX_CONNS)) u_dp (
      .clock, .reset, .cmd, .status,
      .req_func, .req_conn_id, .req_now_us,
      .csr_we, .csr_index, .csr_wdata,
      .rsp_strobe, .rsp_expired_valid, .rsp_expired_conn, .rsp_rejected,
      .rsp_list_empty, .rsp_next_wait_ms, .rsp_last
   );

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the idle connection timeout tracker. Directed and
// random open, activity, close and tick commands are issued in bursts, and
// every result transfer is compared with a local least-recently-active list
// predictor.
// ----------------------------------------------------------------------------
module tb_top
   import ictt_pkg::*;
();

   localparam int NSLOT = DEF_MAX_CONNS;

   typedef struct {
      logic        exp_valid;
      logic [5:0]  exp_conn;
      logic        rejected;
      logic        list_empty;
      logic [31:0] wait_ms;
      logic        last;
   } tracker_rsp_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [1:0]  req_func;
   logic [5:0]  req_conn_id;
   logic [63:0] req_now_us;
   logic        rsp_strobe;
   logic        rsp_expired_valid;
   logic [5:0]  rsp_expired_conn;
   logic        rsp_rejected;
   logic        rsp_list_empty;
   logic [31:0] rsp_next_wait_ms;
   logic        rsp_last;
   logic        csr_we;
   logic        csr_index;
   logic [15:0] csr_wdata;

   // Predictor state: register copies and the slot list.
   logic [15:0] mdl_timeout_ms;
   logic [15:0] mdl_empty_wait;
   logic        mdl_active [NSLOT];
   logic [63:0] mdl_start  [NSLOT];
   logic [5:0]  mdl_next   [NSLOT];
   logic [5:0]  mdl_prev   [NSLOT];
   logic [5:0]  mdl_oldest;
   logic [5:0]  mdl_newest;
   int          mdl_count;

   tracker_rsp_type pending_rsp [$];
   int              error_count;

   // Sender burst state; start_drv mirrors the value last scheduled on start.
   logic        start_drv;
   int          burst_left;
   logic [63:0] now_clk;

   idle_connection_timeout_tracker u_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_func          (req_func),
      .req_conn_id       (req_conn_id),
      .req_now_us        (req_now_us),
      .rsp_strobe        (rsp_strobe),
      .rsp_expired_valid (rsp_expired_valid),
      .rsp_expired_conn  (rsp_expired_conn),
      .rsp_rejected      (rsp_rejected),
      .rsp_list_empty    (rsp_list_empty),
      .rsp_next_wait_ms  (rsp_next_wait_ms),
      .rsp_last          (rsp_last),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   // ------------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------------
   task automatic list_append(input logic [5:0] s);
      if (mdl_count == 0) begin
         mdl_oldest = s;
      end else begin
         mdl_next[mdl_newest] = s;
         mdl_prev[s] = mdl_newest;
      end
      mdl_newest = s;
      mdl_count++;
   endtask

   task automatic list_remove(input logic [5:0] s);
      logic [5:0] p;
      logic [5:0] n;
      p = mdl_prev[s];
      n = mdl_next[s];
      if (s == mdl_oldest) mdl_oldest = n; else mdl_next[p] = n;
      if (s == mdl_newest) mdl_newest = p; else mdl_prev[n] = p;
      mdl_count--;
      if (mdl_count == 0) begin
         mdl_oldest = '0;
         mdl_newest = '0;
      end
   endtask

   // Exact sums on 66 bits: start + timeout*1000 < now + 1000.
   function automatic logic slot_due(input logic [63:0] st, input logic [63:0] now);
      logic [65:0] lhs;
      logic [65:0] rhs;
      lhs = 66'(st) + 66'(mdl_timeout_ms) * 66'(US_PER_MS);
      rhs = 66'(now) + 66'(US_PER_MS);
      return lhs < rhs;
   endfunction

   function automatic logic [31:0] wait_until_expiry(input logic [63:0] now);
      logic [65:0] span;
      logic [65:0] st;
      logic [65:0] ms;
      if (mdl_count == 0) return 32'(mdl_empty_wait);
      span = 66'(mdl_timeout_ms) * 66'(US_PER_MS);
      st   = 66'(mdl_start[mdl_oldest]);
      if (st >= 66'(now)) begin
         ms = (st - 66'(now) + span) / 66'(US_PER_MS);
      end else if (66'(now) - st >= span) begin
         ms = '0;
      end else begin
         ms = (span - (66'(now) - st)) / 66'(US_PER_MS);
      end
      return (ms > 66'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : ms[31:0];
   endfunction

   task automatic predict_command(input func_type f, input logic [5:0] id,
                                  input logic [63:0] now);
      tracker_rsp_type step_rsp [$];
      tracker_rsp_type r;
      logic [5:0]      s;
      logic            rej;
      r = '{default: '0};
      if (f == FUNC_TICK) begin
         while (mdl_count > 0 && step_rsp.size() < MAX_RESULTS &&
                slot_due(mdl_start[mdl_oldest], now)) begin
            s = mdl_oldest;
            list_remove(s);
            mdl_active[s] = 1'b0;
            r.exp_valid = 1'b1;
            r.exp_conn  = s;
            step_rsp = {step_rsp, r};
         end
         if (step_rsp.size() == 0) step_rsp = {step_rsp, r};
      end else begin
         rej = 1'b1;
         if (f == FUNC_OPEN) begin
            if (!mdl_active[id]) begin
               mdl_active[id] = 1'b1;
               mdl_start[id]  = now;
               list_append(id);
               rej = 1'b0;
            end
         end else if (mdl_active[id]) begin
            list_remove(id);
            if (f == FUNC_ACTIVITY) begin
               mdl_start[id] = now;
               list_append(id);
            end else begin
               mdl_active[id] = 1'b0;
            end
            rej = 1'b0;
         end
         r.rejected = rej;
         step_rsp = {step_rsp, r};
      end
      // Empty flag reflects the list after the whole step; wait rides on the last.
      foreach (step_rsp[k]) step_rsp[k].list_empty = (mdl_count == 0);
      step_rsp[$].wait_ms = wait_until_expiry(now);
      step_rsp[$].last    = 1'b1;
      pending_rsp = {pending_rsp, step_rsp};
   endtask

   // ------------------------------------------------------------------------
   // Checking
   // ------------------------------------------------------------------------
   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
      error_count++;
   endtask

   // Sample mid-cycle so the strobe is stable.
   always @(negedge clock) begin
      tracker_rsp_type w;
      if (!reset && rsp_strobe) begin
         if (pending_rsp.size() == 0) begin
            report_mismatch("unexpected transfer", 64'(rsp_expired_conn), 64'd0);
         end else begin
            w = pending_rsp.pop_front();
            if (rsp_expired_valid !== w.exp_valid)
               report_mismatch("expired_valid", 64'(rsp_expired_valid), 64'(w.exp_valid));
            if (rsp_expired_conn !== w.exp_conn)
               report_mismatch("expired_conn", 64'(rsp_expired_conn), 64'(w.exp_conn));
            if (rsp_rejected !== w.rejected)
               report_mismatch("rejected", 64'(rsp_rejected), 64'(w.rejected));
            if (rsp_list_empty !== w.list_empty)
               report_mismatch("list_empty", 64'(rsp_list_empty), 64'(w.list_empty));
            if (rsp_next_wait_ms !== w.wait_ms)
               report_mismatch("next_wait_ms", 64'(rsp_next_wait_ms), 64'(w.wait_ms));
            if (rsp_last !== w.last)
               report_mismatch("last", 64'(rsp_last), 64'(w.last));
         end
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus helpers; each is entered right after a rising edge.
   // ------------------------------------------------------------------------
   task automatic send_command(input func_type f, input logic [5:0] id,
                               input logic [63:0] now);
      if (!start_drv) start <= 1'b1;
      start_drv = 1'b1;
      req_func    <= f;
      req_conn_id <= id;
      req_now_us  <= now;
      // Busy is stable between edges: look at it mid-cycle.
      do @(negedge clock); while (busy);
      @(posedge clock);
      predict_command(f, id, now);
      if (burst_left == 0) begin
         start <= 1'b0;
         start_drv = 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 30)
                                                  : $urandom_range(0, 6);
      end else begin
         burst_left--;
      end
   endtask

   // Hold the sender until every expected transfer has come, then let the
   // block settle.
   task automatic drain_results();
      if (start_drv) start <= 1'b0;
      start_drv = 1'b0;
      while (pending_rsp.size() != 0 || busy) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic write_csr(input csr_idx_type idx, input logic [15:0] val);
      drain_results();
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_TIMEOUT) mdl_timeout_ms = val; else mdl_empty_wait = val;
   endtask

   // Pick an open slot most of the time so activity and close do real work.
   function automatic logic [5:0] pick_slot();
      logic [5:0] s;
      s = 6'($urandom);
      if (mdl_count > 0 && $urandom_range(0, 9) < 8) begin
         while (!mdl_active[s]) s++;
      end
      return s;
   endfunction

   task automatic random_command(input int step_us);
      int          pick;
      func_type    f;
      logic [63:0] now;
      pick = $urandom_range(0, 99);
      if (pick < 35)      f = FUNC_OPEN;
      else if (pick < 60) f = FUNC_ACTIVITY;
      else if (pick < 75) f = FUNC_CLOSE;
      else                f = FUNC_TICK;
      if ($urandom_range(0, 9) == 0) begin
         now = {$urandom, $urandom};
      end else begin
         now_clk += 64'($urandom_range(0, step_us));
         now = now_clk;
      end
      send_command(f, (f == FUNC_OPEN) ? 6'($urandom) : pick_slot(), now);
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------
   task automatic test_basic_ops();
      write_csr(CSR_TIMEOUT, 16'd10);
      write_csr(CSR_EMPTY_WAIT, 16'd0);
      send_command(FUNC_TICK,     6'd0,  64'd0);
      send_command(FUNC_OPEN,     6'd0,  64'd1000);
      send_command(FUNC_OPEN,     6'd63, 64'd2000);
      send_command(FUNC_OPEN,     6'd0,  64'd2500);   // already open
      send_command(FUNC_ACTIVITY, 6'd5,  64'd2600);   // not open
      send_command(FUNC_CLOSE,    6'd7,  64'd2700);   // not open
      send_command(FUNC_OPEN,     6'd5,  64'd3000);
      send_command(FUNC_ACTIVITY, 6'd0,  64'd4000);   // move head to tail
      send_command(FUNC_CLOSE,    6'd63, 64'd4500);
      send_command(FUNC_TICK,     6'd21, 64'd9000);   // nothing due
      send_command(FUNC_TICK,     6'd42, 64'd13500);  // two due, list drains
      send_command(FUNC_CLOSE,    6'd5,  64'd13600);
   endtask

   task automatic test_time_extremes();
      write_csr(CSR_TIMEOUT, 16'hFFFF);
      write_csr(CSR_EMPTY_WAIT, 16'hFFFF);
      send_command(FUNC_OPEN,     6'd9, 64'hFFFF_FFFF_FFFF_FFFF);
      send_command(FUNC_TICK,     6'd0, 64'd0);       // wait saturates
      send_command(FUNC_ACTIVITY, 6'd9, 64'd0);
      send_command(FUNC_TICK,     6'd0, 64'hFFFF_FFFF_FFFF_FFFF);
      write_csr(CSR_TIMEOUT, 16'd0);
      send_command(FUNC_OPEN,     6'd1, 64'd5000);
      send_command(FUNC_TICK,     6'd0, 64'd4001);    // due inside the 1 ms slack
      send_command(FUNC_OPEN,     6'd2, 64'd5000);
      send_command(FUNC_TICK,     6'd0, 64'd4000);    // just short of due
      send_command(FUNC_CLOSE,    6'd2, 64'd0);
   endtask

   task automatic test_random_phase(input logic [15:0] tmo, input logic [15:0] empty_wait,
                                    input int n_items, input int step_us);
      write_csr(CSR_TIMEOUT, tmo);
      write_csr(CSR_EMPTY_WAIT, empty_wait);
      repeat (n_items) random_command(step_us);
   endtask

   // Open every slot, then tick well past the timeout of the slots just opened.
   task automatic test_full_expiry();
      write_csr(CSR_TIMEOUT, 16'd3);
      for (int s = 0; s < NSLOT; s++) begin
         if (!mdl_active[s]) send_command(FUNC_OPEN, 6'(s), now_clk + 64'(s));
      end
      send_command(FUNC_TICK, 6'($urandom), now_clk + 64'd100_000);
      now_clk += 64'd100_000;
   endtask

   initial begin
      reset       = 1'b1;
      start       = 1'b0;
      req_func    = FUNC_OPEN;
      req_conn_id = '0;
      req_now_us  = '0;
      csr_we      = 1'b0;
      csr_index   = CSR_TIMEOUT;
      csr_wdata   = '0;
      start_drv   = 1'b0;
      burst_left  = 0;
      error_count = 0;
      mdl_timeout_ms = TIMEOUT_RST;
      mdl_empty_wait = EMPTY_WAIT_RST;
      foreach (mdl_active[i]) begin
         mdl_active[i] = 1'b0;
         mdl_start[i]  = '0;
         mdl_next[i]   = '0;
         mdl_prev[i]   = '0;
      end
      mdl_oldest = '0;
      mdl_newest = '0;
      mdl_count  = 0;
      now_clk    = 64'd0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_basic_ops();
      test_time_extremes();
      now_clk = 64'd1_000_000;
      test_random_phase(16'd20, 16'd65535, 150, 8000);
      test_random_phase(16'd0, 16'd0, 50, 3000);
      test_random_phase(16'd1, 16'($urandom), 50, 2500);
      test_full_expiry();
      // Start high in time so the upper bits of now_us get exercised.
      now_clk = {$urandom, $urandom} >> 1;
      test_random_phase(16'($urandom_range(2, 40)), 16'($urandom), 70, 12000);
      test_random_phase(16'd5000, 16'd10000, 20, 2_000_000);
      drain_results();

      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   initial begin
      #6_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

>>> filelist.f
hw/rtl/ictt_pkg.sv
hw/rtl/ictt_ram.sv
hw/rtl/ictt_ctrl.sv
hw/rtl/ictt_dp.sv
hw/rtl/idle_connection_timeout_tracker.sv
sim/tb_top.sv
